// ===== src/i2cw_pkg.sv =====
// i2cw_pkg: shared types and constants for the I2C single-byte write serializer.
// No dependencies.
package i2cw_pkg;

  typedef enum logic [1:0] {
    SYM_START = 2'd0,
    SYM_BIT   = 2'd1,
    SYM_ACK   = 2'd2,
    SYM_STOP  = 2'd3
  } sym_e;

  localparam logic [7:0] ADDR_RESET = 8'h78;
  localparam logic [7:0] CTRL_DATA  = 8'h40;
  localparam logic [7:0] CTRL_CMD   = 8'h00;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [4:0] LAST_SYM_IDX = 5'd28;
  localparam logic [3:0] ACK_POS      = 4'd8;

  // The three bytes of one transaction, sent addr first.
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] payload;
  } xfer_t;

endpackage

// ===== src/i2cw_front.sv =====
// i2cw_front: holds the address register and turns each input transaction
// into a three-byte transfer descriptor. Depends on i2cw_pkg.
module i2cw_front import i2cw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [7:0] cfg_data_i,
  input  logic [7:0] payload_i,
  input  logic       is_data_i,
  output xfer_t      xfer_o
);

  logic [7:0] addr_q;
  logic [7:0] addr_d;

  always_comb begin
    addr_d = cfg_valid_i ? cfg_data_i : addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= ADDR_RESET;
    end else begin
      addr_q <= addr_d;
    end
  end

  always_comb begin
    xfer_o.addr    = addr_q;
    xfer_o.ctrl    = is_data_i ? CTRL_DATA : CTRL_CMD;
    xfer_o.payload = payload_i;
  end

endmodule

// ===== src/i2cw_queue.sv =====
// i2cw_queue: small FIFO of transfer descriptors between front and back.
// Depends on i2cw_pkg.
module i2cw_queue import i2cw_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  xfer_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output xfer_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  xfer_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/i2cw_back.sv =====
// i2cw_back: symbol sequencer; plays one descriptor out as 29 bus symbols
// into a registered output stage. Depends on i2cw_pkg.
module i2cw_back import i2cw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  xfer_t      pop_data_i,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic [1:0] m_sym_o,
  output logic       m_sda_o,
  output logic       m_last_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [3:0]  bpos_q, bpos_d;
  logic [23:0] sh_q, sh_d;
  logic        ovld_q, ovld_d;
  sym_e        osym_q, osym_d;
  logic        osda_q, osda_d;
  logic        olast_q, olast_d;
  logic        adv;

  assign adv = !ovld_q || m_ready_i;

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    bpos_d      = bpos_q;
    sh_d        = sh_q;
    ovld_d      = ovld_q;
    osym_d      = osym_q;
    osda_d      = osda_q;
    olast_d     = olast_q;
    pop_ready_o = 1'b0;
    if (adv) begin
      if (busy_q) begin
        ovld_d  = 1'b1;
        osda_d  = 1'b0;
        olast_d = 1'b0;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == '0) begin
          osym_d = SYM_START;
          bpos_d = '0;
        end else if (cnt_q == LAST_SYM_IDX) begin
          osym_d      = SYM_STOP;
          olast_d     = 1'b1;
          pop_ready_o = 1'b1;
          busy_d      = pop_valid_i;
          cnt_d       = '0;
          sh_d        = pop_data_i;
        end else if (bpos_q == ACK_POS) begin
          osym_d = SYM_ACK;
          bpos_d = '0;
        end else begin
          osym_d = SYM_BIT;
          osda_d = sh_q[23];
          sh_d   = {sh_q[22:0], 1'b0};
          bpos_d = bpos_q + 1'b1;
        end
      end else begin
        ovld_d      = 1'b0;
        pop_ready_o = 1'b1;
        busy_d      = pop_valid_i;
        cnt_d       = '0;
        sh_d        = pop_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      bpos_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      bpos_q <= bpos_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    osym_q  <= osym_d;
    osda_q  <= osda_d;
    olast_q <= olast_d;
  end

  assign m_valid_o = ovld_q;
  assign m_sym_o   = osym_q;
  assign m_sda_o   = osda_q;
  assign m_last_o  = olast_q;

endmodule

// ===== src/i2c_single_byte_write_serializer_unit.sv =====
// i2c_single_byte_write_serializer_unit: top level of the serializer.
// Depends on i2cw_pkg, i2cw_front, i2cw_queue, i2cw_back.
//
// Usage:
//   Slave stream: one transaction per byte write; tdata carries the payload,
//   tuser says data (1, control byte 0x40) or command (0, control byte 0x00).
//   Master stream: 29 symbol transactions per byte write: start, address
//   byte, control byte, payload (each 8 bit clocks MSB first plus one ack
//   clock), then stop with tlast set. tuser is the symbol code, tdata[0] the
//   SDA level of a bit clock.
//   Config channel: writes the address byte (reset 0x78); write only while
//   idle. cfg_ready_o is always high.
// Timing:
//   An input transaction is queued, popped by the sequencer and its first
//   symbol registered into the output stage. The sequencer emits one symbol
//   per cycle while the master side is ready; runs follow each other with no
//   gap when the next write is queued. A small queue holds accepted writes,
//   so inputs are taken while the sequencer runs. A stall on the master side
//   freezes the sequencer and the output register; nothing is lost. Reset
//   empties the queue and the sequencer and restores the address byte.
module i2c_single_byte_write_serializer_unit import i2cw_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] payload
  input  logic       s_axis_tuser,  // [0] is_data
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [0] sda_level, [7:1] zero
  output logic [1:0] m_axis_tuser,  // [1:0] symbol
  output logic       m_axis_tlast   // final_symbol
);

  xfer_t xfer_in, xfer_out;
  logic  q_valid, q_ready;
  logic  sda;

  assign cfg_ready_o = 1'b1;

  i2cw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .payload_i   (s_axis_tdata),
    .is_data_i   (s_axis_tuser),
    .xfer_o      (xfer_in)
  );

  i2cw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_data_i  (xfer_in),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (xfer_out)
  );

  i2cw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_valid),
    .pop_ready_o (q_ready),
    .pop_data_i  (xfer_out),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_sym_o     (m_axis_tuser),
    .m_sda_o     (sda),
    .m_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, sda};

endmodule
